// ----- design/ddo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg: shared definitions for the differential drive odometry block
// Widths, register indexes, fixed-point constants, sequencer states and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int ENC_WIDTH_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam int WB_W       = 12;
  localparam int SC_W       = 17;
  localparam int POS_W      = 32;
  localparam int HEAD_W     = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [WB_W-1:0] WB_RESET = 12'd225;
  localparam logic [SC_W-1:0] SC_RESET = 17'd57237;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_SCALE = 1'b1;

  // 2^32 / (2*pi), heading units per radian scaled by 256
  localparam logic [29:0] TURN_SCALE = 30'd683565276;

  // CORDIC datapath width and the start value that cancels the CORDIC gain (Q30)
  localparam int CS_W = 34;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Multiplicand width of the shared multiplier
  localparam int MC_W = 50;

  localparam int SHIFT_LINE = 38;
  localparam int SHIFT_ARC  = 54;
  localparam int MOVE_W     = 41;
  localparam logic [MOVE_W-1:0] MOVE_CAP = 41'h100_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COR1,
    ST_TMUL,
    ST_TDIV,
    ST_RMUL,
    ST_RDIV,
    ST_COR2,
    ST_MOVE,
    ST_BMUL,
    ST_PMUL,
    ST_OUT
  } ddo_state_t;

  // Arctangent of 2^-i, 2^32 units per turn.
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/ddo_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_if: valid/ready channels of the odometry block
// One interface for encoder beats and one for pose beats.
// ----------------------------------------------------------------------------
interface ddo_in_if #(parameter int ENC_WIDTH = 16);
  logic                        valid;
  logic                        ready;
  logic signed [ENC_WIDTH-1:0] left_delta;
  logic signed [ENC_WIDTH-1:0] right_delta;
  modport source (output valid, output left_delta, output right_delta, input ready);
  modport sink   (input valid, input left_delta, input right_delta, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [23:0] heading;
  modport source (output valid, output pos_x, output pos_y, output heading, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface
`default_nettype wire

// ----- design/ddo_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_cordic: iterative rotation CORDIC
// One micro-rotation per cycle; returns sine and cosine in Q30.
// ----------------------------------------------------------------------------
module ddo_cordic import ddo_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [HEAD_W-1:0]      angle,
  output logic                        done,
  output logic signed [CS_W-1:0]      sin_out,
  output logic signed [CS_W-1:0]      cos_out
);

  localparam int NSTEPS = (STEPS > 32) ? 32 : STEPS;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic                   fold_r, fold_nxt;
  logic [4:0]             idx_r, idx_nxt;
  logic signed [CS_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;

  logic [31:0]            u, u2;
  logic                   fold;
  logic signed [CS_W-1:0] dx, dy, at;

  always_comb begin
    u    = {angle, 8'h00};
    // Angles in the back half plane are turned by half a turn first.
    fold = u[31] ^ u[30];
    u2   = fold ? {~u[31], u[30:0]} : u;
    dx   = y_r >>> idx_r;
    dy   = x_r >>> idx_r;
    at   = signed'({2'b00, atan_entry(idx_r)});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    fold_nxt = fold_r;
    idx_nxt  = idx_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      fold_nxt = fold;
      idx_nxt  = 5'd0;
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = signed'({{(CS_W-32){u2[31]}}, u2});
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      idx_nxt = idx_r + 5'd1;
      if (idx_r == 5'(NSTEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    fold_r <= fold_nxt;
    idx_r  <= idx_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign done    = done_r;
  assign sin_out = fold_r ? -y_r : y_r;
  assign cos_out = fold_r ? -x_r : x_r;

endmodule
`default_nettype wire

// ----- design/ddo_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_mul: bit-serial unsigned multiplier
// Consumes one multiplier bit per cycle, stops when the rest are zero.
// ----------------------------------------------------------------------------
module ddo_mul import ddo_pkg::*; #(
  parameter int MCW = MC_W,
  parameter int MLW = 44
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [MCW-1:0]       mcand,
  input  wire logic [MLW-1:0]       mlier,
  output logic                      done,
  output logic [MCW+MLW-1:0]        prod
);

  localparam int P_W = MCW + MLW;

  logic           busy_r, busy_nxt;
  logic [P_W-1:0] acc_r, acc_nxt, mc_r, mc_nxt;
  logic [MLW-1:0] ml_r, ml_nxt;

  always_comb begin
    busy_nxt = busy_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    ml_nxt   = ml_r;
    done     = busy_r && (ml_r == '0);
    if (start) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      mc_nxt   = P_W'(mcand);
      ml_nxt   = mlier;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      if (ml_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt = {mc_r[P_W-2:0], 1'b0};
      ml_nxt = ml_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    ml_r  <= ml_nxt;
  end

  assign prod = acc_r;

endmodule
`default_nettype wire

// ----- design/ddo_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_div: restoring unsigned divider
// One quotient bit per cycle; the divisor must be nonzero.
// ----------------------------------------------------------------------------
module ddo_div import ddo_pkg::*; #(
  parameter int NUMW = 47,
  parameter int DENW = 20
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NUMW-1:0] num,
  input  wire logic [DENW-1:0] den,
  output logic                 done,
  output logic [NUMW-1:0]      quo
);

  localparam int CNT_W = $clog2(NUMW + 1);

  logic            busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DENW-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [NUMW-1:0] quo_r, quo_nxt;
  logic [DENW:0]   rsh, diff;
  logic            ge;

  always_comb begin
    rsh  = {rem_r, quo_r[NUMW-1]};
    diff = rsh - {1'b0, den_r};
    ge   = rsh >= {1'b0, den_r};
    done = busy_r && (cnt_r == CNT_W'(NUMW));

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DENW-1:0] : rsh[DENW-1:0];
      quo_nxt = {quo_r[NUMW-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

// ----- design/differential_drive_odometry.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_odometry: dead-reckoning pose from wheel encoder beats
// Sequencer around a shared CORDIC, a bit-serial multiplier and a divider.
// ----------------------------------------------------------------------------
// Each input beat carries signed left and right encoder increments; the block
// answers with exactly one pose beat (x, y in Q24.8, heading with 2^24 units
// per turn) that already includes the move. Work is done one item at a time:
// a beat with equal increments costs one CORDIC pass plus two pairs of
// bit-serial multiplies; a turning beat adds two divisions of ENC_WIDTH+31
// quotient bits each, two short multiplies and a second CORDIC pass. The
// multiplier stops as soon as the remaining multiplier bits are zero, so
// small increments finish sooner. The finished pose waits in an output
// register, and the next encoder beat is taken as soon as the sequencer is
// back at rest, even if the pose has not yet been taken. Configuration must
// be written only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int ENC_WIDTH    = ENC_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ddo_in_if.sink                     in_ch,
  ddo_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int E     = ENC_WIDTH;
  localparam int NUM_W = E + 31;
  localparam int DEN_W = (E + 2 > 20) ? E + 2 : 20;
  localparam int AM_W  = E + 28;
  localparam int P_W   = MC_W + AM_W;
  localparam int SUM_W = POS_W + 11;

  // Limits of the signed position range, at the width of the sum.
  localparam logic signed [SUM_W-1:0] POS_MAX =
    {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] POS_MIN =
    {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

  ddo_state_t state_r, state_nxt;

  logic [WB_W-1:0]          wb_r;
  logic [SC_W-1:0]          sc_r;
  logic signed [E-1:0]      l_r, l_nxt, r_r, r_nxt;
  logic signed [CS_W-1:0]   s1_r, s1_nxt, c1_r, c1_nxt, s2_r, s2_nxt, c2_r, c2_nxt;
  logic [HEAD_W-1:0]        theta_r, theta_nxt;
  logic [AM_W-1:0]          rmm_r, rmm_nxt;
  logic                     axis_r, axis_nxt;
  logic signed [POS_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic [HEAD_W-1:0]        h_r, h_nxt;
  logic signed [POS_W-1:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic [HEAD_W-1:0]        oh_r, oh_nxt;
  logic                     ov_r, ov_nxt;

  // Shared arithmetic units.
  logic                   cor_start, cor_done;
  logic [HEAD_W-1:0]      cor_angle;
  logic signed [CS_W-1:0] cor_sin, cor_cos;
  logic                   mul_start, mul_done;
  logic [MC_W-1:0]        mul_mc;
  logic [AM_W-1:0]        mul_ml;
  logic [P_W-1:0]         mul_prod;
  logic                   div_start, div_done;
  logic [NUM_W-1:0]       div_num, div_quo;
  logic [DEN_W-1:0]       div_den;

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cor_start), .angle(cor_angle),
    .done(cor_done), .sin_out(cor_sin), .cos_out(cor_cos)
  );

  ddo_mul #(.MCW(MC_W), .MLW(AM_W)) u_mul (
    .clk, .rst_n, .start(mul_start), .mcand(mul_mc), .mlier(mul_ml),
    .done(mul_done), .prod(mul_prod)
  );

  ddo_div #(.NUMW(NUM_W), .DENW(DEN_W)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // Derived quantities of the item in hand.
  logic signed [E:0]      lx, rx, dif, sm;
  logic [E:0]             dm, sum_mag, l_mag;
  logic                   straight;
  logic [WB_W-1:0]        b_eff;
  logic signed [CS_W-1:0] t_sel;
  logic [CS_W-1:0]        t_mag;
  logic [AM_W-1:0]        a_mag;
  logic                   a_neg, mv_neg;
  logic [HEAD_W-1:0]      tm;
  logic [P_W:0]           rnd, res_full;
  logic [MOVE_W-1:0]      capped;
  logic signed [MOVE_W:0] mv;
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [POS_W-1:0] acc_sel, sat_val;
  logic                   out_load;

  always_comb begin
    lx       = {l_r[E-1], l_r};
    rx       = {r_r[E-1], r_r};
    dif      = lx - rx;
    sm       = lx + rx;
    dm       = dif[E] ? unsigned'(-dif) : unsigned'(dif);
    sum_mag  = sm[E] ? unsigned'(-sm) : unsigned'(sm);
    l_mag    = lx[E] ? unsigned'(-lx) : unsigned'(lx);
    straight = (l_r == r_r);
    // A wheel base of zero behaves as one count.
    b_eff    = (wb_r == '0) ? WB_W'(1) : wb_r;

    // Straight moves project the step onto the heading; arcs use the chord
    // from the difference of the two headings.
    if (straight) begin
      t_sel = axis_r ? c1_r : s1_r;
      a_mag = AM_W'(l_mag);
      a_neg = lx[E];
    end else begin
      t_sel = axis_r ? (s2_r - s1_r) : (c1_r - c2_r);
      a_mag = rmm_r;
      a_neg = sm[E] != dif[E];
    end
    t_mag  = t_sel[CS_W-1] ? unsigned'(-t_sel) : unsigned'(t_sel);
    mv_neg = a_neg ^ t_sel[CS_W-1];

    tm = div_quo[HEAD_W-1:0];

    // Round half away from zero on the magnitude, then cap.
    if (straight) begin
      rnd      = {1'b0, mul_prod} + ((P_W+1)'(1) << (SHIFT_LINE - 1));
      res_full = rnd >> SHIFT_LINE;
    end else begin
      rnd      = {1'b0, mul_prod} + ((P_W+1)'(1) << (SHIFT_ARC - 1));
      res_full = rnd >> SHIFT_ARC;
    end
    capped  = (res_full > (P_W+1)'(MOVE_CAP)) ? MOVE_CAP : res_full[MOVE_W-1:0];
    mv      = mv_neg ? -signed'({1'b0, capped}) : signed'({1'b0, capped});
    acc_sel = axis_r ? y_r : x_r;
    acc_sum = SUM_W'(acc_sel) + SUM_W'(mv);
    if (acc_sum > POS_MAX) begin
      sat_val = {1'b0, {(POS_W-1){1'b1}}};
    end else if (acc_sum < POS_MIN) begin
      sat_val = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat_val = acc_sum[POS_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    s1_nxt    = s1_r;
    c1_nxt    = c1_r;
    s2_nxt    = s2_r;
    c2_nxt    = c2_r;
    theta_nxt = theta_r;
    rmm_nxt   = rmm_r;
    axis_nxt  = axis_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    h_nxt     = h_r;
    cor_start = 1'b0;
    cor_angle = h_r;
    mul_start = 1'b0;
    mul_mc    = '0;
    mul_ml    = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    out_load  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          l_nxt     = in_ch.left_delta;
          r_nxt     = in_ch.right_delta;
          cor_start = 1'b1;
          state_nxt = ST_COR1;
        end
      end
      ST_COR1: begin
        if (cor_done) begin
          s1_nxt   = cor_sin;
          c1_nxt   = cor_cos;
          axis_nxt = 1'b0;
          if (straight) begin
            state_nxt = ST_MOVE;
          end else begin
            mul_start = 1'b1;
            mul_mc    = MC_W'(TURN_SCALE);
            mul_ml    = AM_W'(dm);
            state_nxt = ST_TMUL;
          end
        end
      end
      ST_TMUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = mul_prod[NUM_W-1:0] + NUM_W'({b_eff, 7'h00});
          div_den   = DEN_W'({b_eff, 8'h00});
          state_nxt = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (div_done) begin
          theta_nxt = dif[E] ? (HEAD_W'(0) - tm) : tm;
          mul_start = 1'b1;
          mul_mc    = MC_W'(sum_mag);
          mul_ml    = AM_W'(b_eff);
          state_nxt = ST_RMUL;
        end
      end
      ST_RMUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = {mul_prod[NUM_W-17:0], 16'h0000} + NUM_W'(dm);
          div_den   = DEN_W'({dm, 1'b0});
          state_nxt = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (div_done) begin
          rmm_nxt   = div_quo[AM_W-1:0];
          cor_start = 1'b1;
          cor_angle = h_r + theta_r;
          state_nxt = ST_COR2;
        end
      end
      ST_COR2: begin
        if (cor_done) begin
          s2_nxt    = cor_sin;
          c2_nxt    = cor_cos;
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        mul_start = 1'b1;
        mul_mc    = MC_W'(t_mag);
        mul_ml    = AM_W'(sc_r);
        state_nxt = ST_BMUL;
      end
      ST_BMUL: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_mc    = mul_prod[MC_W-1:0];
          mul_ml    = a_mag;
          state_nxt = ST_PMUL;
        end
      end
      ST_PMUL: begin
        if (mul_done) begin
          if (axis_r) begin
            y_nxt = sat_val;
            if (!straight) h_nxt = h_r + theta_r;
            state_nxt = ST_OUT;
          end else begin
            x_nxt     = sat_val;
            axis_nxt  = 1'b1;
            state_nxt = ST_MOVE;
          end
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    ox_nxt = out_load ? x_r : ox_r;
    oy_nxt = out_load ? y_r : oy_r;
    oh_nxt = out_load ? h_r : oh_r;
    if (out_load) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      x_r     <= '0;
      y_r     <= '0;
      h_r     <= '0;
      ov_r    <= 1'b0;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      h_r     <= h_nxt;
      ov_r    <= ov_nxt;
      axis_r  <= axis_nxt;
    end
    l_r     <= l_nxt;
    r_r     <= r_nxt;
    s1_r    <= s1_nxt;
    c1_r    <= c1_nxt;
    s2_r    <= s2_nxt;
    c2_r    <= c2_nxt;
    theta_r <= theta_nxt;
    rmm_r   <= rmm_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oh_r    <= oh_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= WB_RESET;
      sc_r <= SC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WHEEL_BASE: wb_r <= cfg_data[WB_W-1:0];
        REG_DIST_SCALE: sc_r <= cfg_data[SC_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = ov_r;
  assign out_ch.pos_x   = ox_r;
  assign out_ch.pos_y   = oy_r;
  assign out_ch.heading = oh_r;

  // An accepted beat always starts the first CORDIC pass.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == ST_COR1)
    else $error("accepted beat did not start the CORDIC pass");

  // The pose only moves while an item is being worked on.
  a_idle_pose: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |=> $stable(x_r) && $stable(y_r) && $stable(h_r))
    else $error("pose changed while idle");

  // Leaving the output state always leaves a pose beat on offer.
  a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |=> out_ch.valid)
    else $error("result state left no pose beat");

endmodule
`default_nettype wire

// ----- sim/differential_drive_odometry_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_test: self-checking bench for the odometry block
// Encoder beats are driven from a queue, and each one updates a local pose
// predictor. Each pose beat is compared with the oldest predicted pose. The
// run covers several register settings, idle patterns on both channels and
// one long output stall.
// ----------------------------------------------------------------------------
module differential_drive_odometry_test import ddo_pkg::*;;

  typedef struct packed {
    logic signed [ENC_WIDTH_DEF-1:0] left;
    logic signed [ENC_WIDTH_DEF-1:0] right;
  } enc_beat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [HEAD_W-1:0]       head;
  } pose_t;

  // Arctangent of 2^-i in 2^32 units per turn.
  localparam longint ATAN_LUT [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};

  localparam longint unsigned STEP_CAP = 64'd1 << 40;
  localparam int              SETTLE   = 400;
  localparam int              STALL_LIMIT = 40000;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ddo_in_if #(.ENC_WIDTH(ENC_WIDTH_DEF)) in_if ();
  ddo_out_if out_if ();

  differential_drive_odometry u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Free-running clock, 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Local copy of the pose and the two registers.
  logic [WB_W-1:0]         model_wheel_base;
  logic [SC_W-1:0]         model_scale;
  logic signed [POS_W-1:0] model_x;
  logic signed [POS_W-1:0] model_y;
  logic [HEAD_W-1:0]       model_head;

  enc_beat_t enc_queue[$];
  pose_t     pose_queue[$];

  int  error_count;
  int  tx_idle_pct;
  int  rx_idle_pct;
  int  hold_requests;
  int  hold_served;
  int  hold_left;
  int  stall_cycles;
  logic in_took;

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Fixed-length CORDIC in rotation mode. Angles outside the right half plane
  // are folded by half a turn and the result negated afterwards.
  task automatic cordic_rotate(input logic [HEAD_W-1:0] angle,
                               output longint sin_q30, output longint cos_q30);
    logic [31:0] u;
    logic [31:0] probe;
    logic        fold;
    longint      cx, cy, z, sx, sy;
    u = {angle, 8'd0};
    probe = u + 32'h4000_0000;
    fold = probe[31];
    if (fold) u = u + 32'h8000_0000;
    z = longint'($signed(u));
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
      sx = cy >>> i;
      sy = cx >>> i;
      if (z >= 0) begin
        cx = cx - sx;
        cy = cy + sy;
        z  = z - ATAN_LUT[i];
      end else begin
        cx = cx + sx;
        cy = cy - sy;
        z  = z + ATAN_LUT[i];
      end
    end
    if (fold) begin
      cx = -cx;
      cy = -cy;
    end
    sin_q30 = cy;
    cos_q30 = cx;
  endtask

  // Rounded a*t*scale / 2^shift with the magnitude capped.
  function automatic longint scaled_step(input longint a, input longint t,
                                         input longint unsigned scale, input int shift);
    logic [127:0]    prod;
    longint unsigned res;
    logic            neg;
    neg  = (a < 0) != (t < 0);
    prod = {64'd0, magnitude(a)} * {64'd0, magnitude(t) * scale};
    prod = prod + (128'd1 << (shift - 1));
    prod = prod >> shift;
    res  = (prod > {64'd0, STEP_CAP}) ? STEP_CAP : prod[63:0];
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_add(input logic signed [POS_W-1:0] acc,
                                                        input longint d);
    longint s;
    s = longint'(acc) + d;
    if (s > 64'sd2147483647) return 32'sh7fff_ffff;
    if (s < -64'sd2147483648) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  // Advances the local pose by one encoder beat and returns the new pose.
  task automatic advance_pose(input enc_beat_t beat, output pose_t pose);
    longint l, r, s1, c1, s2, c2, dx, dy, d, sum, rm;
    longint unsigned dm, b, tm, rmm;
    logic [HEAD_W-1:0] theta;
    l = beat.left;
    r = beat.right;
    cordic_rotate(model_head, s1, c1);
    if (l == r) begin
      dx = scaled_step(l, s1, model_scale, SHIFT_LINE);
      dy = scaled_step(l, c1, model_scale, SHIFT_LINE);
    end else begin
      d   = l - r;
      sum = l + r;
      dm  = magnitude(d);
      // A wheel base of zero behaves as one.
      b   = (model_wheel_base == 0) ? 64'd1 : 64'(model_wheel_base);
      tm  = (dm * 64'd683565276 + b * 128) / (b * 256);
      theta = tm[HEAD_W-1:0];
      if (d < 0) theta = -theta;
      rmm = (((magnitude(sum) * b) << 16) + dm) / (2 * dm);
      rm  = ((sum < 0) != (d < 0)) ? -longint'(rmm) : longint'(rmm);
      cordic_rotate(model_head + theta, s2, c2);
      dx = scaled_step(rm, c1 - c2, model_scale, SHIFT_ARC);
      dy = scaled_step(rm, s2 - s1, model_scale, SHIFT_ARC);
      model_head = model_head + theta;
    end
    model_x = clamp_add(model_x, dx);
    model_y = clamp_add(model_y, dy);
    pose.x = model_x;
    pose.y = model_y;
    pose.head = model_head;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Input side: each accepted beat is predicted at the rising edge.
  always @(posedge clk) begin
    pose_t p;
    if (rst_n && in_if.valid && in_if.ready) begin
      advance_pose('{in_if.left_delta, in_if.right_delta}, p);
      pose_queue.push_back(p);
    end
    in_took <= rst_n && in_if.valid && in_if.ready;
  end

  // Driver: a new beat is offered at the falling edge once the last one left.
  always @(negedge clk) begin
    enc_beat_t nb;
    if (rst_n && (in_took || !in_if.valid)) begin
      if (enc_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nb = enc_queue.pop_front();
        in_if.left_delta  <= nb.left;
        in_if.right_delta <= nb.right;
        in_if.valid       <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every pose beat against the oldest prediction.
  always @(posedge clk) begin
    pose_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pose_queue.size() == 0) begin
        report_mismatch("unpredicted pose beats", 1, 0);
      end else begin
        w = pose_queue.pop_front();
        if (out_if.pos_x !== w.x) report_mismatch("pos_x", out_if.pos_x, w.x);
        if (out_if.pos_y !== w.y) report_mismatch("pos_y", out_if.pos_y, w.y);
        if (out_if.heading !== w.head) report_mismatch("heading", out_if.heading, w.head);
      end
    end
  end

  // Receiver ready, with a long hold-off whenever one is requested so that the
  // output register fills and the block stops taking encoder beats.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog on cycles without any beat moving on either channel.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Waits until every queued beat is taken and every pose has come back, then
  // lets the sequencer settle before anything else happens.
  task automatic drain;
    wait (enc_queue.size() == 0 && !in_if.valid && pose_queue.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WHEEL_BASE) model_wheel_base = val[WB_W-1:0];
    else model_scale = val[SC_W-1:0];
  endtask

  task automatic add_beat(input int l, input int r);
    enc_queue.push_back('{l[15:0], r[15:0]});
  endtask

  // Random encoder beats: mostly plausible motion, some full-range noise.
  task automatic add_random(input int count);
    int l, d;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2: add_beat($urandom, $urandom);
        3, 4: begin
          l = int'($urandom_range(65535)) - 32768;
          add_beat(l, l);
        end
        5, 6: add_beat(int'($urandom_range(600)) - 300, int'($urandom_range(600)) - 300);
        7, 8: begin
          // Near-straight moves give large turn radii.
          l = int'($urandom_range(60000)) - 30000;
          d = int'($urandom_range(8)) - 4;
          add_beat(l, l + d);
        end
        default: add_beat($urandom_range(1) ? 32767 : -32768,
                          $urandom_range(1) ? 32767 : -32768);
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_WHEEL_BASE;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.left_delta = '0;
    in_if.right_delta = '0;
    out_if.ready = 1'b0;
    in_took = 1'b0;
    error_count = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    stall_cycles = 0;
    tx_idle_pct = 22;
    rx_idle_pct = 85;
    model_wheel_base = WB_RESET;
    model_scale = SC_RESET;
    model_x = '0;
    model_y = '0;
    model_head = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats at the reset settings: field extremes, straight moves,
    // pure spins, and one-wheel turns in both directions.
    add_beat(0, 0);
    add_beat(32767, 32767);
    add_beat(-32768, -32768);
    add_beat(32767, -32768);
    add_beat(-32768, 32767);
    add_beat(1, 0);
    add_beat(0, 1);
    add_beat(-1, 0);
    add_beat(100, -100);
    add_beat(-100, 100);
    add_beat(32767, 32766);
    add_beat(-32768, -32767);
    add_beat(5, 5);
    add_beat(0, -32768);
    add_beat(-32768, 0);
    add_beat(32767, 0);
    add_beat(1000, 900);
    add_beat(-1, -1);
    drain();

    // A wheel base of zero, the largest scale.
    write_reg(REG_WHEEL_BASE, CFG_DATA_W'(0));
    write_reg(REG_DIST_SCALE, 17'h1ffff);
    add_beat(32767, 0);
    add_beat(-32768, 32767);
    add_random(100);
    drain();

    // Widest wheel base with a zero scale: the position must not move.
    write_reg(REG_WHEEL_BASE, CFG_DATA_W'(4095));
    write_reg(REG_DIST_SCALE, CFG_DATA_W'(0));
    add_random(100);
    drain();

    tx_idle_pct = 85;
    rx_idle_pct = 22;
    write_reg(REG_WHEEL_BASE, CFG_DATA_W'(1));
    write_reg(REG_DIST_SCALE, CFG_DATA_W'(65536));
    add_random(100);
    drain();

    // Long straight runs at full scale drive both axes into saturation.
    write_reg(REG_WHEEL_BASE, CFG_DATA_W'(4095));
    write_reg(REG_DIST_SCALE, 17'h1ffff);
    repeat (80) add_beat(32767, 32767);
    add_beat(32767, 0);
    repeat (80) add_beat(-32768, -32768);
    add_beat(-32768, 32767);
    repeat (60) add_beat(32767, 32767);
    drain();

    // No idling, and one long output stall while beats keep coming.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_WHEEL_BASE, CFG_DATA_W'($urandom_range(4095, 1)));
    write_reg(REG_DIST_SCALE, CFG_DATA_W'($urandom_range(131071)));
    add_random(150);
    hold_requests = hold_requests + 1;
    drain();

    write_reg(REG_WHEEL_BASE, CFG_DATA_W'(WB_RESET));
    write_reg(REG_DIST_SCALE, CFG_DATA_W'(SC_RESET));
    add_random(150);
    drain();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
